@@ rtl/fmrt_pkg.sv @@
// Package for the floor match and remove table.
// Holds the default sizes, opcodes, the sequencer state type and the scan control struct.
// No dependencies.
`default_nettype none

package fmrt_pkg;

  // Default sizes, handed to the top level parameters.
  localparam int unsigned FMRT_CAPACITY   = 1024;
  localparam int unsigned FMRT_VALUE_BITS = 30;

  // Operation codes carried in the low field of the input transfer.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_BID   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_CLAIM
  } fmrt_state_t;

  // Control from the sequencer to the compare unit.
  typedef struct packed {
    logic start;  // new bid: forget the previous best
    logic upd;    // read data valid this cycle
  } fmrt_cmp_ctl_t;

endpackage

`default_nettype wire

@@ rtl/fmrt_store.sv @@
// Entry memory: value plus claimed bit, one write port, one registered read port.
// Depends on fmrt_pkg.
`default_nettype none

module fmrt_store
  import fmrt_pkg::*;
#(
  parameter int unsigned CAPACITY   = FMRT_CAPACITY,
  parameter int unsigned VALUE_BITS = FMRT_VALUE_BITS,
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  wire logic                  clk,
  input  wire logic                  wr_en,
  input  wire logic [IW-1:0]         wr_addr,
  input  wire logic [VALUE_BITS:0]   wr_data,   // {claimed, value}
  input  wire logic [IW-1:0]         rd_addr,
  output logic      [VALUE_BITS:0]   rd_data_r  // {claimed, value}
);

  logic [VALUE_BITS:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/fmrt_cmp.sv @@
// Shared compare unit: keeps the best unclaimed value not above the bid.
// Depends on fmrt_pkg.
`default_nettype none

module fmrt_cmp
  import fmrt_pkg::*;
#(
  parameter int unsigned CAPACITY   = FMRT_CAPACITY,
  parameter int unsigned VALUE_BITS = FMRT_VALUE_BITS,
  localparam int unsigned IW = $clog2(CAPACITY)
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire fmrt_cmp_ctl_t           ctl,
  input  wire logic [VALUE_BITS-1:0]   bid,
  input  wire logic [VALUE_BITS:0]     rd_data,   // {claimed, value}
  input  wire logic [IW-1:0]           rd_idx,
  output logic                         hit_r,
  output logic      [VALUE_BITS-1:0]   best_val_r,
  output logic      [IW-1:0]           best_idx_r
);

  logic                  hit_nxt;
  logic [VALUE_BITS-1:0] best_val_nxt;
  logic [IW-1:0]         best_idx_nxt;
  logic [VALUE_BITS-1:0] cur_val;
  logic                  take;

  assign cur_val = rd_data[VALUE_BITS-1:0];
  // strict greater keeps the lowest index among equal values
  assign take = ctl.upd && !rd_data[VALUE_BITS] && (cur_val <= bid) &&
                (!hit_r || (cur_val > best_val_r));

  always_comb begin
    hit_nxt      = hit_r;
    best_val_nxt = best_val_r;
    best_idx_nxt = best_idx_r;
    if (ctl.start) begin
      hit_nxt = 1'b0;
    end else if (take) begin
      hit_nxt      = 1'b1;
      best_val_nxt = cur_val;
      best_idx_nxt = rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_val_r <= best_val_nxt;
    best_idx_r <= best_idx_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/floor_match_and_remove_table_unit.sv @@
// Floor match and remove table: top level with sequencer and output register.
// Depends on fmrt_pkg, fmrt_store, fmrt_cmp.
//
//  channel | ports     | tdata (low bit up)            | tuser
//  --------+-----------+-------------------------------+-------
//  input   | in_*      | opcode[1:0], amount           | -
//  result  | out_*     | matched_value (signed, -1=no) | found
//
// Clear and add are applied when accepted. A bid passes through the accept
// step, one memory read per stored entry through a single comparator (no reads
// when the table is empty), a drain of the read pipe, and a claim step that
// writes the claim and loads the result register.
// Stored entries carry their claimed bit in the memory; an add writes it as zero
// and a clear only resets the fill count, so no clearing pass follows reset.
// A pending result does not block clear or add; a bid waits in its claim step
// until the result register is free.
`default_nettype none

module floor_match_and_remove_table_unit
  import fmrt_pkg::*;
#(
  parameter int unsigned CAPACITY   = FMRT_CAPACITY,
  parameter int unsigned VALUE_BITS = FMRT_VALUE_BITS,
  localparam int unsigned IW    = $clog2(CAPACITY),
  localparam int unsigned CW    = $clog2(CAPACITY + 1),
  localparam int unsigned IN_W  = ((2 + VALUE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((VALUE_BITS + 1 + 7) / 8) * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [IN_W-1:0]  in_tdata,   // opcode[1:0], amount[VALUE_BITS-1:0], zero pad
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic      [OUT_W-1:0] out_tdata,  // matched_value[VALUE_BITS:0], zero pad
  output logic                  out_tuser   // found
);

  fmrt_state_t state_r, state_nxt;

  logic [CW-1:0]         count_r, count_nxt;
  logic [IW-1:0]         idx_r, idx_nxt;
  logic [IW-1:0]         rd_idx_r;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [VALUE_BITS-1:0] bid_r;

  logic                  out_vld_r, out_vld_nxt;
  logic [VALUE_BITS:0]   out_val_r;
  logic                  out_found_r;

  logic [1:0]            in_op;
  logic [VALUE_BITS-1:0] in_amt;
  logic                  in_xfer;
  logic                  last_issue;
  logic                  claim_go;

  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [VALUE_BITS:0]   wr_data;
  logic [VALUE_BITS:0]   rd_data;

  fmrt_cmp_ctl_t         cmp_ctl;
  logic                  hit;
  logic [VALUE_BITS-1:0] best_val;
  logic [IW-1:0]         best_idx;

  assign in_op   = in_tdata[1:0];
  assign in_amt  = in_tdata[2 +: VALUE_BITS];
  assign in_xfer = in_tvalid && in_tready;

  assign last_issue = (CW'(idx_r) == (count_r - CW'(1)));
  assign claim_go   = !out_vld_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_op == OP_BID)) begin
          state_nxt = (count_r == '0) ? ST_CLAIM : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_issue) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_CLAIM;
      ST_CLAIM: begin
        if (claim_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_tready     = 1'b0;
    cmp_ctl.start = 1'b0;
    cmp_ctl.upd   = rd_vld_r;
    rd_vld_nxt    = 1'b0;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    wr_en         = 1'b0;
    wr_addr       = best_idx;
    wr_data       = {1'b1, best_val};
    out_vld_nxt   = out_vld_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        idx_nxt   = '0;
        if (in_xfer) begin
          case (in_op)
            OP_CLEAR: count_nxt = '0;
            OP_ADD: begin
              if (count_r != CW'(CAPACITY)) begin
                wr_en     = 1'b1;
                wr_addr   = count_r[IW-1:0];
                wr_data   = {1'b0, in_amt};
                count_nxt = count_r + CW'(1);
              end
            end
            OP_BID: cmp_ctl.start = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_vld_nxt = 1'b1;
        idx_nxt    = idx_r + IW'(1);
      end
      ST_DRAIN: ;
      ST_CLAIM: begin
        if (claim_go) begin
          wr_en       = hit;
          out_vld_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      count_r   <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    rd_idx_r <= idx_r;
    if (in_xfer) begin
      bid_r <= in_amt;
    end
    if ((state_r == ST_CLAIM) && claim_go) begin
      out_val_r   <= hit ? {1'b0, best_val} : '1;
      out_found_r <= hit;
    end
  end

  fmrt_store #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (idx_r),
    .rd_data_r (rd_data)
  );

  fmrt_cmp #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
  ) u_cmp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (cmp_ctl),
    .bid        (bid_r),
    .rd_data    (rd_data),
    .rd_idx     (rd_idx_r),
    .hit_r      (hit),
    .best_val_r (best_val),
    .best_idx_r (best_idx)
  );

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_W'(out_val_r);
  assign out_tuser  = out_found_r;

endmodule

`default_nettype wire

@@ sim/floor_match_and_remove_table_unit_test.sv @@
// Testbench for floor_match_and_remove_table_unit: directed and random clear/add/bid traffic,
// checked against a cycle-free predictor of the table held in this file.
// Depends on fmrt_pkg and the unit under test only.
`default_nettype none

module floor_match_and_remove_table_unit_test;
  import fmrt_pkg::*;

  localparam int unsigned CAP   = FMRT_CAPACITY;
  localparam int unsigned VB    = FMRT_VALUE_BITS;
  localparam int unsigned IN_W  = ((2 + VB + 7) / 8) * 8;
  localparam int unsigned OUT_W = ((VB + 1 + 7) / 8) * 8;

  // Opcode 3 has no meaning; the block must drop it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [VB-1:0] AMOUNT_MAX = '1;

  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 580;

  // One bid outcome: claimed value (or all ones) plus found flag.
  typedef struct packed {
    logic [VB:0] value;
    logic        found;
  } floor_match_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // opcode[1:0], amount[VB-1:0], zero pad
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;  // matched_value[VB:0], zero pad
  logic             out_tuser;  // found

  floor_match_and_remove_table_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // ---------------------------------------------------------------------------
  // Predicted table contents. Entries at or above held_count are never read.
  // ---------------------------------------------------------------------------
  logic [VB-1:0] held_value   [CAP];
  bit            held_claimed [CAP];
  int unsigned   held_count;

  floor_match_t  expected_matches[$];  // bid outcomes not yet seen on out_*
  int unsigned   mismatch_count;

  bit no_idle;       // both sides run flat out while set
  bit hold_request;  // asks the result side for one long hold-off

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs on a handshake.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Largest unclaimed held value not above limit; lowest index wins a tie.
  function automatic floor_match_t claim_floor(input logic [VB-1:0] limit);
    floor_match_t res;
    int           best;
    best = -1;
    for (int k = 0; k < int'(held_count); k++) begin
      if (!held_claimed[k] && held_value[k] <= limit) begin
        if (best < 0 || held_value[k] > held_value[best]) best = k;
      end
    end
    if (best >= 0) begin
      held_claimed[best] = 1'b1;
      res.value = {1'b0, held_value[best]};
      res.found = 1'b1;
    end else begin
      res.value = '1;
      res.found = 1'b0;
    end
    return res;
  endfunction

  // Apply one accepted transfer to the predicted table.
  function automatic void update_table(input logic [1:0] op, input logic [VB-1:0] amt);
    case (op)
      OP_CLEAR: begin
        held_count = 0;
        for (int k = 0; k < int'(CAP); k++) held_claimed[k] = 1'b0;
      end
      OP_ADD: begin
        if (held_count < CAP) begin
          held_value[held_count]   = amt;
          held_claimed[held_count] = 1'b0;
          held_count++;
        end
      end
      OP_BID: expected_matches.push_back(claim_floor(amt));
      default: ;
    endcase
  endfunction

  // Offer one item, with a random gap first; returns at the accepting edge.
  // Valid stays high across back-to-back items.
  task automatic send_item(input logic [1:0] op, input logic [VB-1:0] amt);
    if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!no_idle && $urandom_range(99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {amt, op};
    do @(posedge clk); while (!in_tready);
    update_table(op, amt);
  endtask

  // Add values: half full-range, a quarter tiny (duplicates), a quarter near the top.
  function automatic logic [VB-1:0] pick_add_value();
    case ($urandom_range(3))
      0:       return VB'($urandom_range(0, 15));
      1:       return AMOUNT_MAX - VB'($urandom_range(0, 15));
      default: return VB'($urandom);
    endcase
  endfunction

  // Bid amounts aimed at held values, just below and just above them, random, and the extremes.
  function automatic logic [VB-1:0] pick_bid_amount();
    logic [VB-1:0] base;
    if (held_count == 0) return VB'($urandom);
    base = held_value[$urandom_range(0, held_count - 1)];
    case ($urandom_range(7))
      0:       return '0;
      1:       return AMOUNT_MAX;
      2:       return VB'($urandom);
      3:       return (base == '0) ? base : base - 1'b1;
      4:       return (base > AMOUNT_MAX - 3) ? AMOUNT_MAX : base + VB'($urandom_range(1, 3));
      default: return base;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: checks each transfer against the oldest expectation and
  // drives out_tready (random idling, or a counted long hold-off on request).
  // ---------------------------------------------------------------------------
  initial begin : result_side
    int unsigned  hold_left;
    floor_match_t want;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_matches.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual value %0d found %b",
                   $time, $signed(out_tdata[VB:0]), out_tuser);
        end else begin
          want = expected_matches.pop_front();
          if (out_tdata[VB:0] !== want.value) begin
            mismatch_count++;
            $display("%0t: matched_value mismatch: expected %0d, actual %0d", $time,
                     $signed(want.value), $signed(out_tdata[VB:0]));
          end
          if (out_tuser !== want.found) begin
            mismatch_count++;
            $display("%0t: found mismatch: expected %b, actual %b", $time,
                     want.found, out_tuser);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (no_idle) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bids on a table that is empty after reset and after a clear.
  task automatic test_empty_table();
    send_item(OP_BID, '0);
    send_item(OP_CLEAR, '0);
    send_item(OP_BID, AMOUNT_MAX);
  endtask

  // Extreme values, equal values, claims used up, and the unused opcode.
  task automatic test_duplicates_and_extremes();
    send_item(OP_ADD, '0);
    send_item(OP_ADD, AMOUNT_MAX);
    send_item(OP_ADD, VB'(7));
    send_item(OP_ADD, VB'(7));
    send_item(OP_ADD, {(VB/2){2'b10}});
    send_item(OP_ADD, {(VB/2){2'b01}});
    send_item(OP_UNUSED, VB'(7));      // must not add an entry
    send_item(OP_BID, AMOUNT_MAX);     // top value
    send_item(OP_BID, AMOUNT_MAX);     // next lower once top is claimed
    send_item(OP_BID, VB'(7));         // equal values: first copy
    send_item(OP_BID, VB'(7));         // second copy
    send_item(OP_BID, VB'(7));         // falls back to zero
    send_item(OP_BID, VB'(6));         // nothing left below
    send_item(OP_UNUSED, AMOUNT_MAX);
    send_item(OP_BID, '0);
    send_item(OP_CLEAR, '0);           // claimed marks gone, count zero
    send_item(OP_ADD, VB'(7));
    send_item(OP_BID, VB'(7));
  endtask

  // Fill to capacity, then one add that must be dropped.
  task automatic test_full_table();
    send_item(OP_CLEAR, '0);
    for (int k = 0; k < int'(CAP); k++) send_item(OP_ADD, VB'($urandom_range(100, 1 << 20)));
    send_item(OP_ADD, VB'(5));         // table full: dropped
    send_item(OP_BID, VB'(5));         // would hit the dropped value
    send_item(OP_BID, AMOUNT_MAX);
    send_item(OP_BID, VB'(1 << 19));
    send_item(OP_BID, pick_bid_amount());
    send_item(OP_CLEAR, '0);
    send_item(OP_BID, AMOUNT_MAX);
  endtask

  // Result side stalls for a long time while bids keep coming: the output
  // register fills, the next bid parks in its claim step and in_tready drops.
  task automatic test_result_backpressure();
    send_item(OP_CLEAR, '0);
    for (int k = 0; k < 12; k++) send_item(OP_ADD, pick_add_value());
    hold_request = 1'b1;
    for (int k = 0; k < 8; k++) send_item(OP_BID, pick_bid_amount());
  endtask

  // Runs of clear, adds, then bids with the odd add and junk opcode mixed in.
  task automatic test_random_traffic();
    int unsigned items_done;
    int unsigned n_adds;
    int unsigned n_bids;
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      no_idle = (items_done >= 240 && items_done < 330);
      // Usually start fresh; sometimes keep appending to the old contents.
      if (held_count > 60 || $urandom_range(7) != 0) begin
        send_item(OP_CLEAR, VB'($urandom));
        items_done++;
      end
      n_adds = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40);
      for (int k = 0; k < int'(n_adds); k++) begin
        send_item(OP_ADD, pick_add_value());
        items_done++;
      end
      n_bids = $urandom_range(1, n_adds + 3);
      for (int k = 0; k < int'(n_bids); k++) begin
        case ($urandom_range(19))
          0: send_item(OP_UNUSED, VB'($urandom));   // ignored, not counted
          1, 2: begin
            send_item(OP_ADD, pick_add_value());
            items_done++;
          end
          default: begin
            send_item(OP_BID, pick_bid_amount());
            items_done++;
          end
        endcase
      end
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    held_count     = 0;
    mismatch_count = 0;
    no_idle        = 1'b0;
    hold_request   = 1'b0;
    for (int k = 0; k < int'(CAP); k++) held_claimed[k] = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_duplicates_and_extremes();
    test_full_table();
    test_result_backpressure();
    test_random_traffic();

    in_tvalid <= 1'b0;
    // Every bid gives a result, so once the queue drains only a short tail
    // of add/clear work can remain; the hard stop above bounds the wait.
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
